>>> rtl/tkfc_pkg.sv
package tkfc_pkg;

  localparam int unsigned BLOCK   = 4096;
  localparam int unsigned MAX_TOP = 64;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned FILL_W  = 13;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned K_W     = 7;
  localparam int unsigned LIST_N  = MAX_TOP + 1;
  localparam int unsigned LIST_W  = 7;
  localparam int unsigned RANK_W  = 6;

  localparam logic [K_W-1:0]   TOPK_RESET = K_W'(10);
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  // one classified item passed from front to back
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic              store;
    logic              last;
    logic              ovf;
    logic [FILL_W-1:0] n;
  } item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEG,
    ST_MRD,
    ST_MWR,
    ST_CSTART,
    ST_CRD,
    ST_CCMP,
    ST_CFIN,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/top_k_frequent_candidates.sv
// Ranking: after its last transfer in, a block of stored items is merge sorted
// in passes (a read state and a write state per element), then run counted;
// top_k result transfers follow, one a cycle while out_stall_i is low.
// Throughput: one input transfer a cycle while loading; a two-entry queue
// absorbs items while the back end sorts, counts and emits.
// Reset (rst_ni low, async): counts, flags, queue, result valid cleared, top_k 10.
module top_k_frequent_candidates (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        top_k_we_i,
  input  logic [6:0]  top_k_i,
  // candidate stream
  input  logic [31:0] candidate_id_i,
  input  logic        block_end_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  // ranked results
  output logic [31:0] result_id_o,
  output logic [12:0] result_count_o,
  output logic        overflowed_o,
  output logic        final_rank_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);
  import tkfc_pkg::*;

  item_t item;
  logic  item_valid, item_pop;

  // front: store address allocation, overflow marking, item queue
  tkfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .candidate_id_i (candidate_id_i),
    .block_end_i    (block_end_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  // back: candidate store, merge sort, run count, top list, result register
  tkfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .item_pop_o     (item_pop),
    .top_k_we_i     (top_k_we_i),
    .top_k_i        (top_k_i),
    .result_id_o    (result_id_o),
    .result_count_o (result_count_o),
    .overflowed_o   (overflowed_o),
    .final_rank_o   (final_rank_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_id_o) &&
      $stable(result_count_o) && $stable(overflowed_o) && $stable(final_rank_o));

  // handshake outputs never unknown
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o) && !$isunknown(in_stall_o));

  // result flags known whenever a result is offered
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(final_rank_o) && !$isunknown(overflowed_o));

endmodule

>>> rtl/tkfc_front.sv
module tkfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         candidate_id_i,
  input  logic                block_end_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output tkfc_pkg::item_t     item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);
  import tkfc_pkg::*;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  item_t             fifo_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, st;
  item_t             cls;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rp_q];

  // classify: slot in the store, or dropped past BLOCK
  always_comb begin
    st        = (fill_q < FILL_W'(BLOCK));
    cls.id    = candidate_id_i;
    cls.addr  = fill_q[ADDR_W-1:0];
    cls.store = st;
    cls.last  = block_end_i;
    cls.ovf   = ovf_q | !st;
    cls.n     = st ? fill_q + FILL_W'(1) : fill_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    if (push) begin
      if (block_end_i) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else begin
        fill_d = cls.n;
        ovf_d  = cls.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      if (push) wp_q <= !wp_q;
      if (item_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(item_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cls;
  end

endmodule

>>> rtl/tkfc_back.sv
module tkfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkfc_pkg::item_t     item_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  input  logic                top_k_we_i,
  input  logic [6:0]          top_k_i,
  output logic [31:0]         result_id_o,
  output logic [12:0]         result_count_o,
  output logic                overflowed_o,
  output logic                final_rank_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import tkfc_pkg::*;

  state_e state_q, state_d;

  logic [ID_W-1:0]   mem0 [BLOCK];
  logic [ID_W-1:0]   mem1 [BLOCK];
  logic [ID_W-1:0]   r0a_q, r0b_q, r1a_q, r1b_q, da, db;

  logic [K_W-1:0]    top_k_q, k_q;
  logic [FILL_W-1:0] n_q;
  logic              ovf_q, src_q;
  logic [POS_W-1:0]  w_q, lo_q, mid_q, hi_q, i_q, j_q, o_q, n_ext;
  logic [POS_W-1:0]  mid_c, hi_c;
  logic [ID_W-1:0]   cur_id_q;
  logic [CNT_W-1:0]  cur_cnt_q;
  logic [RANK_W-1:0] r_q;

  logic [ID_W-1:0]   lid_q  [LIST_N];
  logic [CNT_W-1:0]  lcnt_q [LIST_N];
  logic [LIST_N-1:0] lv_q, ge;

  logic              take_a, seg_done, pass_done, last_rank, emit_go;
  logic              ins_en, w0_en, w1_en;
  logic [ADDR_W-1:0] w0_addr;
  logic [ID_W-1:0]   w0_data, wdata;
  logic [LIST_W-1:0] idx;
  logic              skip;

  logic              ov_q;
  logic [ID_W-1:0]   oid_q;
  logic [CNT_W-1:0]  ocnt_q;
  logic              oovf_q, ofin_q;

  assign n_ext     = POS_W'(n_q);
  assign da        = src_q ? r1a_q : r0a_q;
  assign db        = src_q ? r1b_q : r0b_q;
  assign mid_c     = (lo_q + w_q < n_ext) ? lo_q + w_q : n_ext;
  assign hi_c      = (lo_q + (w_q << 1) < n_ext) ? lo_q + (w_q << 1) : n_ext;
  assign take_a    = (i_q < mid_q) && ((j_q >= hi_q) || (da <= db));
  assign wdata     = take_a ? da : db;
  assign seg_done  = (o_q + POS_W'(1) == hi_q);
  assign pass_done = (lo_q >= n_ext);
  assign emit_go   = !ov_q || !out_stall_i;
  assign last_rank = (K_W'(r_q) == k_q - K_W'(1));
  assign skip      = lv_q[0] && (lid_q[0] == '0);
  assign idx       = LIST_W'(r_q) + LIST_W'(skip);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (item_valid_i && item_i.last) begin
          state_d = (item_i.n > FILL_W'(1)) ? ST_SEG : ST_CSTART;
        end
      end
      ST_SEG: begin
        if (pass_done && ((w_q << 1) >= n_ext)) state_d = ST_CSTART;
        else if (!pass_done) state_d = ST_MRD;
      end
      ST_MRD:    state_d = ST_MWR;
      ST_MWR:    state_d = seg_done ? ST_SEG : ST_MRD;
      ST_CSTART: state_d = ST_CRD;
      ST_CRD:    state_d = ST_CCMP;
      ST_CCMP:   state_d = (i_q + POS_W'(1) == n_ext) ? ST_CFIN : ST_CRD;
      ST_CFIN:   state_d = ST_EMIT;
      ST_EMIT:   if (emit_go && last_rank) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  // control strobes
  always_comb begin
    item_pop_o = (state_q == ST_LOAD) && item_valid_i;
    ins_en     = ((state_q == ST_CCMP) && (cur_cnt_q != '0) && (da != cur_id_q))
                 || (state_q == ST_CFIN);
    w1_en      = (state_q == ST_MWR) && !src_q;
    w0_en      = ((state_q == ST_MWR) && src_q) || (item_pop_o && item_i.store);
    w0_addr    = (state_q == ST_MWR) ? o_q[ADDR_W-1:0] : item_i.addr;
    w0_data    = (state_q == ST_MWR) ? wdata : item_i.id;
  end

  // sorted insertion: ties keep the earlier (smaller) ID ahead
  always_comb begin
    for (int e = 0; e < LIST_N; e++) begin
      ge[e] = lv_q[e] && (lcnt_q[e] >= cur_cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (w0_en) mem0[w0_addr] <= w0_data;
    if (w1_en) mem1[o_q[ADDR_W-1:0]] <= wdata;
    r0a_q <= mem0[i_q[ADDR_W-1:0]];
    r0b_q <= mem0[j_q[ADDR_W-1:0]];
    r1a_q <= mem1[i_q[ADDR_W-1:0]];
    r1b_q <= mem1[j_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      if (!ge[0]) begin
        lid_q[0]  <= cur_id_q;
        lcnt_q[0] <= cur_cnt_q;
      end
      for (int e = 1; e < LIST_N; e++) begin
        if (!ge[e]) begin
          if (ge[e-1]) begin
            lid_q[e]  <= cur_id_q;
            lcnt_q[e] <= cur_cnt_q;
          end else begin
            lid_q[e]  <= lid_q[e-1];
            lcnt_q[e] <= lcnt_q[e-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      top_k_q   <= TOPK_RESET;
      lv_q      <= '0;
      ov_q      <= 1'b0;
      src_q     <= 1'b0;
      n_q       <= '0;
      ovf_q     <= 1'b0;
      w_q       <= '0;
      lo_q      <= '0;
      mid_q     <= '0;
      hi_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      o_q       <= '0;
      cur_cnt_q <= '0;
      r_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      if (top_k_we_i) top_k_q <= top_k_i;
      if (state_q == ST_EMIT && emit_go) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (ins_en) begin
        lv_q[0] <= 1'b1;
        for (int e = 1; e < LIST_N; e++) begin
          lv_q[e] <= ge[e] || lv_q[e-1];
        end
      end
      unique case (state_q)
        ST_LOAD: begin
          if (item_pop_o && item_i.last) begin
            n_q   <= item_i.n;
            ovf_q <= item_i.ovf;
            w_q   <= POS_W'(1);
            lo_q  <= '0;
            src_q <= 1'b0;
          end
        end
        ST_SEG: begin
          if (pass_done) begin
            src_q <= !src_q;
            w_q   <= w_q << 1;
            lo_q  <= '0;
          end else begin
            mid_q <= mid_c;
            hi_q  <= hi_c;
            i_q   <= lo_q;
            j_q   <= mid_c;
            o_q   <= lo_q;
          end
        end
        ST_MWR: begin
          o_q <= o_q + POS_W'(1);
          if (take_a) i_q <= i_q + POS_W'(1);
          else j_q <= j_q + POS_W'(1);
          if (seg_done) lo_q <= hi_q;
        end
        ST_CSTART: begin
          i_q       <= '0;
          cur_cnt_q <= '0;
          lv_q      <= '0;
        end
        ST_CCMP: begin
          i_q <= i_q + POS_W'(1);
          if (cur_cnt_q != '0 && da == cur_id_q) begin
            if (cur_cnt_q != COUNT_MAX) cur_cnt_q <= cur_cnt_q + CNT_W'(1);
          end else begin
            cur_cnt_q <= CNT_W'(1);
          end
        end
        ST_CFIN: begin
          r_q <= '0;
          if (top_k_q == '0) k_q <= K_W'(1);
          else if (top_k_q > K_W'(MAX_TOP)) k_q <= K_W'(MAX_TOP);
          else k_q <= top_k_q;
        end
        ST_EMIT: begin
          if (emit_go) r_q <= r_q + RANK_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CCMP && !(cur_cnt_q != '0 && da == cur_id_q)) cur_id_q <= da;
    if (state_q == ST_EMIT && emit_go) begin
      oid_q  <= lv_q[idx] ? lid_q[idx] : '0;
      ocnt_q <= lv_q[idx] ? lcnt_q[idx] : '0;
      oovf_q <= ovf_q;
      ofin_q <= last_rank;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_id_o    = oid_q;
  assign result_count_o = ocnt_q;
  assign overflowed_o   = oovf_q;
  assign final_rank_o   = ofin_q;

endmodule

>>> tb/sv/top_k_frequent_candidates_test.sv
module top_k_frequent_candidates_test;
  import tkfc_pkg::*;

  // one ranked entry, as the block reports it
  typedef struct {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic             fin;
  } rank_t;

  // Scoreboard: collects the current block, ranks it on block_end and
  // queues the expected ranked transfers; results are checked in order.
  class rank_board;
    rank_t             ranked_q[$];
    logic [ID_W-1:0]   block_q[$];
    logic              dropped;
    logic [K_W-1:0]    k_reg;
    int                errors;
    int                seen;

    function new();
      dropped = 1'b0;
      k_reg   = TOPK_RESET;
      errors  = 0;
      seen    = 0;
    endfunction

    function void set_k(logic [K_W-1:0] v);
      k_reg = v;
    endfunction

    function int pending();
      return ranked_q.size();
    endfunction

    // note one accepted candidate transfer
    function void note_item(logic [ID_W-1:0] id, logic last);
      int unsigned tally [logic [ID_W-1:0]];
      rank_t       order [$];
      rank_t       e;
      int          k, skip, pos;
      if (block_q.size() < BLOCK) block_q.push_back(id);
      else dropped = 1'b1;
      if (!last) return;
      foreach (block_q[i]) begin
        if (tally.exists(block_q[i])) tally[block_q[i]]++;
        else tally[block_q[i]] = 1;
      end
      // insertion sort: count descending, then id ascending
      foreach (tally[key]) begin
        e.id  = key;
        e.cnt = (tally[key] > COUNT_MAX) ? COUNT_MAX : CNT_W'(tally[key]);
        pos = 0;
        while (pos < order.size() && (order[pos].cnt > e.cnt ||
               (order[pos].cnt == e.cnt && order[pos].id < e.id)))
          pos++;
        order.insert(pos, e);
      end
      // padding at the very top is dropped, lower ranks keep id 0
      skip = (order.size() > 0 && order[0].id == '0) ? 1 : 0;
      k = (k_reg == 0) ? 1 : (k_reg > MAX_TOP) ? MAX_TOP : int'(k_reg);
      for (int r = 0; r < k; r++) begin
        if (skip + r < order.size()) e = order[skip + r];
        else begin
          e.id  = '0;
          e.cnt = '0;
        end
        e.ovf = dropped;
        e.fin = (r == k - 1);
        ranked_q.push_back(e);
      end
      block_q.delete();
      dropped = 1'b0;
    endfunction

    function void check_rank(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt,
                             logic ovf, logic fin);
      rank_t e;
      seen++;
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected result id=%h count=%0d", $time, id, cnt);
        errors++;
        return;
      end
      e = ranked_q.pop_front();
      if (id !== e.id) begin
        $display("%0t: result_id expected %h actual %h", $time, e.id, id);
        errors++;
      end
      if (cnt !== e.cnt) begin
        $display("%0t: result_count expected %0d actual %0d", $time, e.cnt, cnt);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflowed expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
      if (fin !== e.fin) begin
        $display("%0t: final_rank expected %b actual %b", $time, e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;  // longest quiet stretch is the HOLD_LEN output hold
  localparam int HOLD_LEN   = 600;

  logic        clk;
  logic        rst_n;
  logic        top_k_we;
  logic [6:0]  top_k_val;
  logic [31:0] cand_id;
  logic        blk_end;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] res_id;
  logic [12:0] res_cnt;
  logic        res_ovf;
  logic        res_fin;
  logic        out_valid;
  logic        out_stall;

  rank_board board;
  bit        quiet;      // no idling in the closing stretch
  bit        hold_done;
  int        hold_left;
  int        idle_cycles;
  int        rand_items;

  top_k_frequent_candidates dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .top_k_we_i     (top_k_we),
    .top_k_i        (top_k_val),
    .candidate_id_i (cand_id),
    .block_end_i    (blk_end),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .result_id_o    (res_id),
    .result_count_o (res_cnt),
    .overflowed_o   (res_ovf),
    .final_rank_o   (res_fin),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: random stall bursts, plus one long hold-off so the
  // block backs up and stalls its input
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && board != null && board.seen >= 10) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // monitor and watchdog, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_rank(res_id, res_cnt, res_ovf, res_fin);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one candidate and hold it until the transfer completes
  task automatic send_cand(logic [31:0] id, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    cand_id  = id;
    blk_end  = last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_item(id, last);
    @(negedge clk);
  endtask

  // top_k may only change while nothing is in flight
  task automatic write_top_k(logic [6:0] v);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    top_k_we  = 1'b1;
    top_k_val = v;
    @(negedge clk);
    top_k_we  = 1'b0;
    board.set_k(v);
  endtask

  // random block: mostly a small id pool so counts and ties build up
  task automatic random_block();
    int          len;
    int          mode;
    logic [31:0] id;
    len  = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       id = $urandom_range(0, 3);
        1:       id = $urandom_range(0, 9);
        2:       id = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5);
        default: id = $urandom;
      endcase
      send_cand(id, i == len - 1);
      rand_items++;
      if (rand_items > 190) quiet = 1'b1;
    end
  endtask

  initial begin
    logic [6:0] k_plan [7];
    board       = new();
    rst_n       = 1'b0;
    top_k_we    = 1'b0;
    top_k_val   = '0;
    cand_id     = '0;
    blk_end     = 1'b0;
    in_valid    = 1'b0;
    quiet       = 1'b0;
    idle_cycles = 0;
    rand_items  = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, with top_k at its reset value
    send_cand(32'h0, 1'b1);                       // lone padding: all slots padded
    send_cand(32'hFFFF_FFFF, 1'b0);
    send_cand(32'hFFFF_FFFF, 1'b0);
    send_cand(32'h0, 1'b0);
    send_cand(32'h0, 1'b0);
    send_cand(32'h0, 1'b0);                       // padding on top, skipped
    send_cand(32'h1, 1'b1);
    send_cand(32'h5, 1'b0);                       // ties, id 0 at a lower rank
    send_cand(32'h3, 1'b0);
    send_cand(32'h5, 1'b0);
    send_cand(32'h3, 1'b0);
    send_cand(32'h7, 1'b0);
    send_cand(32'h0, 1'b1);
    send_cand(32'hAAAA_AAAA, 1'b0);
    send_cand(32'h5555_5555, 1'b1);

    k_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd3, 7'd10};
    foreach (k_plan[p]) begin
      write_top_k((p == 6) ? 7'($urandom_range(1, 64)) : k_plan[p]);
      repeat (3) random_block();
    end
    while (rand_items < 215) random_block();
    in_valid = 1'b0;

    while (board.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
